FILE: rtl/swbr_pkg.sv
`default_nettype none

package swbr_pkg;

    // Fixed field widths
    localparam int unsigned LEVEL_W = 12;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned CHG_W   = 4;
    localparam int unsigned STRIP_W = 3;
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned CFG_W   = 32;

    // Read completes after this many colour changes
    localparam logic [CHG_W-1:0]   CHANGES_PER_READ = 4'd8;
    localparam logic [CHG_W-1:0]   CHG_MAX          = 4'd15;
    localparam logic [STRIP_W-1:0] STRIP_MAX        = 3'd7;

    // Register reset values
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 12'd2684;
    localparam logic [TIME_W-1:0]  WIDTH_RESET = 32'd505;

    // Register indexes
    typedef enum logic [0:0] {
        CFG_LEVEL = 1'b0,
        CFG_WIDTH = 1'b1
    } cfg_index_t;

    // Item commands
    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_START  = 2'd1,
        MODE_STOP   = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_threshold;
        logic [TIME_W-1:0]  width_threshold_ms;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [LEVEL_W-1:0] sensor_level;
        logic [TIME_W-1:0]  time_ms;
    } item_t;

    typedef struct packed {
        logic               strip_done;
        logic               strip_bit;
        logic [TIME_W-1:0]  strip_width_ms;
        logic [STRIP_W-1:0] strips_seen;
        logic [CHG_W-1:0]   changes_seen;
        logic [CODE_W-1:0]  code_value;
        logic               reading;
        logic               finished;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/swbr_cfg.sv
`default_nettype none

module swbr_cfg
    import swbr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [LEVEL_W-1:0] level_reg;
    logic [TIME_W-1:0]  width_reg;

    // Write the selected threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= LEVEL_RESET;
            width_reg <= WIDTH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LEVEL: level_reg <= cfg_data[LEVEL_W-1:0];
                CFG_WIDTH: width_reg <= cfg_data[TIME_W-1:0];
            endcase
        end
    end

    assign cfg.level_threshold    = level_reg;
    assign cfg.width_threshold_ms = width_reg;

endmodule

`default_nettype wire

FILE: rtl/swbr_decode.sv
`default_nettype none

module swbr_decode
    import swbr_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  step,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result
);

    logic               last_white_reg, last_white_next;
    logic [CHG_W-1:0]   change_count_reg, change_count_next;
    logic [TIME_W-1:0]  strip_start_reg, strip_start_next;
    logic               in_strip_reg, in_strip_next;
    logic               active_reg, active_next;
    logic               done_reg, done_next;
    logic [STRIP_W-1:0] strip_count_reg, strip_count_next;
    logic [CODE_W-1:0]  code_reg, code_next;

    logic               white;
    logic               ended;
    logic               bit_val;
    logic [TIME_W-1:0]  width;

    assign white = item.sensor_level > cfg.level_threshold;

    // Decode one item against the read state
    always_comb begin
        last_white_next   = last_white_reg;
        change_count_next = change_count_reg;
        strip_start_next  = strip_start_reg;
        in_strip_next     = in_strip_reg;
        active_next       = active_reg;
        done_next         = done_reg;
        strip_count_next  = strip_count_reg;
        code_next         = code_reg;
        ended             = 1'b0;
        bit_val           = 1'b0;
        width             = '0;

        unique case (mode_t'(item.mode))
            MODE_START: begin
                if (!active_reg) begin
                    last_white_next   = white;
                    change_count_next = '0;
                    strip_start_next  = '0;
                    in_strip_next     = 1'b0;
                    active_next       = 1'b1;
                    done_next         = 1'b0;
                    strip_count_next  = '0;
                    code_next         = '0;
                end
            end
            MODE_STOP: begin
                active_next = 1'b0;
            end
            MODE_SAMPLE: begin
                if (active_reg && !done_reg) begin
                    if (white != last_white_reg) begin
                        if (change_count_reg != CHG_MAX) begin
                            change_count_next = change_count_reg + 1'b1;
                        end
                        if (white) begin
                            strip_start_next = item.time_ms;
                            in_strip_next    = 1'b1;
                        end else if (in_strip_reg) begin
                            // End a white strip and shift its bit into the code
                            width         = item.time_ms - strip_start_reg;
                            in_strip_next = 1'b0;
                            if (strip_count_reg != STRIP_MAX) begin
                                strip_count_next = strip_count_reg + 1'b1;
                            end
                            bit_val   = !(width < cfg.width_threshold_ms);
                            code_next = {code_reg[CODE_W-2:0], bit_val};
                            ended     = 1'b1;
                        end
                        last_white_next = white;
                    end
                    if (change_count_next >= CHANGES_PER_READ) begin
                        done_next   = 1'b1;
                        active_next = 1'b0;
                    end
                end
            end
            MODE_NOP: begin
            end
        endcase
    end

    // Advance the read state once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_white_reg   <= 1'b0;
            change_count_reg <= '0;
            strip_start_reg  <= '0;
            in_strip_reg     <= 1'b0;
            active_reg       <= 1'b0;
            done_reg         <= 1'b0;
            strip_count_reg  <= '0;
            code_reg         <= '0;
        end else if (step) begin
            last_white_reg   <= last_white_next;
            change_count_reg <= change_count_next;
            strip_start_reg  <= strip_start_next;
            in_strip_reg     <= in_strip_next;
            active_reg       <= active_next;
            done_reg         <= done_next;
            strip_count_reg  <= strip_count_next;
            code_reg         <= code_next;
        end
    end

    assign result.strip_done     = ended;
    assign result.strip_bit      = bit_val;
    assign result.strip_width_ms = width;
    assign result.strips_seen    = strip_count_next;
    assign result.changes_seen   = change_count_next;
    assign result.code_value     = code_next;
    assign result.reading        = active_next;
    assign result.finished       = done_next;

    a_active_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        !(active_reg && done_reg))
        else $error("read active and finished at once");

    a_change_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        change_count_reg <= CHANGES_PER_READ)
        else $error("change count beyond read length");

    a_strip_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        strip_count_reg <= 3'd4)
        else $error("more than four strips in one read");

    a_strip_counts_change: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.strip_done |-> result.changes_seen == change_count_reg + 1'b1)
        else $error("strip ended without a counted change");

endmodule

`default_nettype wire

FILE: rtl/strip_width_barcode_reader.sv
`default_nettype none

// Strip width barcode reader. Each input beat carries a command (sample, start,
// stop, no-op), a 12-bit reflectance sample and a wrapping millisecond timestamp,
// and yields exactly one result beat with the strip just ended (if any) and the
// read status after the update. One beat is taken per clock while the result
// register is free or being drained by m_ready; an accepted beat is held in the
// input register, updates the read state as it moves into the result register,
// and is presented from there. Thresholds are written through cfg_we/cfg_index/
// cfg_data; the user must write them only while idle, which the block does not enforce.
module strip_width_barcode_reader
    import swbr_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [MODE_W-1:0]  s_mode,
    input  wire logic [LEVEL_W-1:0] s_sensor_level,
    input  wire logic [TIME_W-1:0]  s_time_ms,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_strip_done,
    output logic                    m_strip_bit,
    output logic [TIME_W-1:0]       m_strip_width_ms,
    output logic [STRIP_W-1:0]      m_strips_seen,
    output logic [CHG_W-1:0]        m_changes_seen,
    output logic [CODE_W-1:0]       m_code_value,
    output logic                    m_reading,
    output logic                    m_finished
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    result_t result;
    logic    advance;

    swbr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move the held beat into the result register when it is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    swbr_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.mode         <= s_mode;
            in_item_reg.sensor_level <= s_sensor_level;
            in_item_reg.time_ms      <= s_time_ms;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_strip_done     = out_reg.strip_done;
    assign m_strip_bit      = out_reg.strip_bit;
    assign m_strip_width_ms = out_reg.strip_width_ms;
    assign m_strips_seen    = out_reg.strips_seen;
    assign m_changes_seen   = out_reg.changes_seen;
    assign m_code_value     = out_reg.code_value;
    assign m_reading        = out_reg.reading;
    assign m_finished       = out_reg.finished;

endmodule

`default_nettype wire
